[rtl/core/tlpt_pkg.sv]
// Shared types and constants for the two-level page table manager.
// No dependencies; tlpt_ctrl and the top level in rtl/core import this package.
package tlpt_pkg;

  // Default geometry of the directory and the table pool.
  localparam int unsigned DirBitsDef    = 10;
  localparam int unsigned TableBitsDef  = 10;
  localparam int unsigned PoolTablesDef = 16;

  // Field positions within a 32-bit virtual address.
  localparam int unsigned DirLsb     = 22;
  localparam int unsigned TableLsb   = 12;
  localparam int unsigned OffsetBits = 12;
  localparam int unsigned FlagBits   = 12;

  typedef enum logic [1:0] {
    OP_MAP       = 2'd0,
    OP_UNMAP     = 2'd1,
    OP_TRANSLATE = 2'd2
  } operation_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POOL_FULL = 2'd1,
    ST_MISS      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIR,
    S_CLEAR,
    S_MAPW,
    S_ENT,
    S_HOLD
  } ctrl_state_e;

endpackage

[rtl/core/tlpt_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Depends on nothing.
module tlpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tlpt_ctrl.sv]
// Sequencer of the page table manager: directory lookup, table allocation
// and clearing, entry update or lookup, and the output register.
// Depends on tlpt_pkg; drives the two tlpt_ram instances of the top level.
module tlpt_ctrl #(
  parameter int unsigned DIR_BITS    = tlpt_pkg::DirBitsDef,
  parameter int unsigned TABLE_BITS  = tlpt_pkg::TableBitsDef,
  parameter int unsigned POOL_TABLES = tlpt_pkg::PoolTablesDef,
  parameter int unsigned SLOT_W      = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   operation_i,
  input  logic [31:0]                  virt_addr_i,
  input  logic [31:0]                  phys_addr_i,
  input  logic [11:0]                  entry_flags_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [31:0]                  translated_addr_o,
  output logic [1:0]                   status_o,
  output logic                         dir_we_o,
  output logic [DIR_BITS-1:0]          dir_waddr_o,
  output logic [SLOT_W:0]              dir_wdata_o,
  output logic                         dir_re_o,
  output logic [DIR_BITS-1:0]          dir_raddr_o,
  input  logic [SLOT_W:0]              dir_rdata_i,
  output logic                         ent_we_o,
  output logic [SLOT_W+TABLE_BITS-1:0] ent_waddr_o,
  output logic [31:0]                  ent_wdata_o,
  output logic                         ent_re_o,
  output logic [SLOT_W+TABLE_BITS-1:0] ent_raddr_o,
  input  logic [31:0]                  ent_rdata_i
);
  import tlpt_pkg::*;

  localparam int unsigned CntW = $clog2(POOL_TABLES + 1);

  ctrl_state_e state_q, state_d;

  logic [1:0]            op_q;
  logic [DIR_BITS-1:0]   dix_q;
  logic [TABLE_BITS-1:0] tix_q;
  logic [OffsetBits-1:0] off_q;
  logic [31:0]           map_word_q;

  logic [CntW-1:0]       count_q, count_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [DIR_BITS-1:0]   dir_clr_q, dir_clr_d;
  logic [TABLE_BITS-1:0] tbl_clr_q, tbl_clr_d;

  logic [31:0] res_addr_q, res_addr_d;
  logic [1:0]  res_status_q, res_status_d;
  logic        out_valid_q;
  logic [31:0] out_addr_q;
  logic [1:0]  out_status_q;

  logic              accept;
  logic              hit;
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] new_slot;
  logic              out_free;
  logic              finish;
  logic              out_load;
  logic [31:0]       fin_addr;
  logic [1:0]        fin_status;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign hit        = dir_rdata_i[SLOT_W];
  assign rd_slot    = dir_rdata_i[SLOT_W-1:0];
  assign new_slot   = count_q[SLOT_W-1:0];
  assign out_free   = !out_valid_q || out_ready_i;

  // The directory is looked up straight from the incoming word.
  assign dir_re_o    = accept;
  assign dir_raddr_o = virt_addr_i[DirLsb +: DIR_BITS];
  assign ent_raddr_o = {rd_slot, tix_q};

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    slot_d       = slot_q;
    dir_clr_d    = dir_clr_q;
    tbl_clr_d    = tbl_clr_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    finish       = 1'b0;
    out_load     = 1'b0;
    fin_addr     = '0;
    fin_status   = ST_OK;
    dir_we_o     = 1'b0;
    dir_waddr_o  = dix_q;
    dir_wdata_o  = {1'b1, new_slot};
    ent_we_o     = 1'b0;
    ent_waddr_o  = {rd_slot, tix_q};
    ent_wdata_o  = map_word_q;
    ent_re_o     = 1'b0;

    case (state_q)
      S_INIT: begin
        // Clear every directory valid bit once after reset.
        dir_we_o    = 1'b1;
        dir_waddr_o = dir_clr_q;
        dir_wdata_o = '0;
        dir_clr_d   = dir_clr_q + 1'b1;
        if (dir_clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DIR;
        end
      end
      S_DIR: begin
        case (op_q)
          OP_MAP: begin
            if (hit) begin
              ent_we_o = 1'b1;
              finish   = 1'b1;
            end else if (count_q == CntW'(POOL_TABLES)) begin
              fin_status = ST_POOL_FULL;
              finish     = 1'b1;
            end else begin
              dir_we_o  = 1'b1;
              slot_d    = new_slot;
              count_d   = count_q + 1'b1;
              tbl_clr_d = '0;
              state_d   = S_CLEAR;
            end
          end
          OP_UNMAP: begin
            ent_we_o    = hit;
            ent_wdata_o = '0;
            finish      = 1'b1;
          end
          OP_TRANSLATE: begin
            if (hit) begin
              ent_re_o = 1'b1;
              state_d  = S_ENT;
            end else begin
              fin_status = ST_MISS;
              finish     = 1'b1;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_CLEAR: begin
        ent_we_o    = 1'b1;
        ent_waddr_o = {slot_q, tbl_clr_q};
        ent_wdata_o = '0;
        tbl_clr_d   = tbl_clr_q + 1'b1;
        if (tbl_clr_q == '1) begin
          state_d = S_MAPW;
        end
      end
      S_MAPW: begin
        ent_we_o    = 1'b1;
        ent_waddr_o = {slot_q, tix_q};
        finish      = 1'b1;
      end
      S_ENT: begin
        if (ent_rdata_i[0]) begin
          fin_addr = {ent_rdata_i[31:OffsetBits], off_q};
        end else begin
          fin_status = ST_MISS;
        end
        finish = 1'b1;
      end
      S_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A finished result goes straight to the output register when it is
    // free, otherwise it is parked until the consumer takes the last word.
    if (finish) begin
      res_addr_d   = fin_addr;
      res_status_d = fin_status;
      if (out_free) begin
        out_load = 1'b1;
        state_d  = S_IDLE;
      end else begin
        state_d = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      count_q     <= '0;
      dir_clr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dir_clr_q <= dir_clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q       <= slot_d;
    tbl_clr_q    <= tbl_clr_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (accept) begin
      op_q       <= operation_i;
      dix_q      <= virt_addr_i[DirLsb +: DIR_BITS];
      tix_q      <= virt_addr_i[TableLsb +: TABLE_BITS];
      off_q      <= virt_addr_i[OffsetBits-1:0];
      map_word_q <= {phys_addr_i[31:OffsetBits], entry_flags_i};
    end
    if (out_load) begin
      out_addr_q   <= res_addr_d;
      out_status_q <= res_status_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign translated_addr_o = out_addr_q;
  assign status_o          = out_status_q;

endmodule

[rtl/core/two_level_page_table_manager.sv]
// Top level of the two-level page table manager: sequencer plus directory
// and entry memories. Depends on tlpt_pkg, tlpt_ram and tlpt_ctrl.
//
//   Channel   Direction  Handshake           Word
//   input     in         in_valid_i/ready_o  operation, virt_addr, phys_addr, entry_flags
//   output    out        out_valid_o/ready_i translated_addr, status
//
// Map to an existing table, unmap, a translate miss and an unused code
// finish on the directory read; a translate hit reads the entry after it.
// A map that allocates a table first has the single entry memory write port
// sweep the new table to zero one entry a cycle, then writes the entry.
// After reset the directory is swept before the first word is taken. A
// stalled output holds the finished word; a further word is taken as soon as
// the sequencer is idle, and its result waits for the stall.
module two_level_page_table_manager #(
  parameter int unsigned DIR_BITS    = tlpt_pkg::DirBitsDef,
  parameter int unsigned TABLE_BITS  = tlpt_pkg::TableBitsDef,
  parameter int unsigned POOL_TABLES = tlpt_pkg::PoolTablesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] virt_addr_i,
  input  logic [31:0] phys_addr_i,
  input  logic [11:0] entry_flags_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] translated_addr_o,
  output logic [1:0]  status_o
);
  import tlpt_pkg::*;

  localparam int unsigned SlotW    = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int unsigned EntAw    = SlotW + TABLE_BITS;
  localparam int unsigned EntDepth = POOL_TABLES << TABLE_BITS;
  localparam int unsigned DirDepth = 1 << DIR_BITS;

  logic                dir_we, dir_re;
  logic [DIR_BITS-1:0] dir_waddr, dir_raddr;
  logic [SlotW:0]      dir_wdata, dir_rdata;
  logic                ent_we, ent_re;
  logic [EntAw-1:0]    ent_waddr, ent_raddr;
  logic [31:0]         ent_wdata, ent_rdata;

  tlpt_ctrl #(
    .DIR_BITS    (DIR_BITS),
    .TABLE_BITS  (TABLE_BITS),
    .POOL_TABLES (POOL_TABLES),
    .SLOT_W      (SlotW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .virt_addr_i       (virt_addr_i),
    .phys_addr_i       (phys_addr_i),
    .entry_flags_i     (entry_flags_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .translated_addr_o (translated_addr_o),
    .status_o          (status_o),
    .dir_we_o          (dir_we),
    .dir_waddr_o       (dir_waddr),
    .dir_wdata_o       (dir_wdata),
    .dir_re_o          (dir_re),
    .dir_raddr_o       (dir_raddr),
    .dir_rdata_i       (dir_rdata),
    .ent_we_o          (ent_we),
    .ent_waddr_o       (ent_waddr),
    .ent_wdata_o       (ent_wdata),
    .ent_re_o          (ent_re),
    .ent_raddr_o       (ent_raddr),
    .ent_rdata_i       (ent_rdata)
  );

  // Directory: valid bit above the table slot number.
  tlpt_ram #(
    .WIDTH (SlotW + 1),
    .DEPTH (DirDepth),
    .AW    (DIR_BITS)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .re_i    (dir_re),
    .raddr_i (dir_raddr),
    .rdata_o (dir_rdata)
  );

  // Second-level entries of all pool tables, addressed by slot and index.
  tlpt_ram #(
    .WIDTH (32),
    .DEPTH (EntDepth),
    .AW    (EntAw)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

endmodule

[tb/sv/tlpt_walk_checker.sv]
// Checker for the two-level page table manager: follows both channels, keeps
// its own copy of the directory and the table pool, and compares each result.
// Depends on tlpt_pkg for the operation and status codes and the default geometry.
module tlpt_walk_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  operation_i,
  input  logic [31:0] virt_addr_i,
  input  logic [31:0] phys_addr_i,
  input  logic [11:0] entry_flags_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] translated_addr_i,
  input  logic [1:0]  status_i,
  output int unsigned error_count_o,
  output int unsigned pending_count_o
);
  import tlpt_pkg::*;

  localparam int unsigned DirEntries   = 1 << DirBitsDef;
  localparam int unsigned TableEntries = 1 << TableBitsDef;
  localparam int unsigned StoreEntries = PoolTablesDef * TableEntries;
  localparam logic [31:0] FrameMask    = 32'hFFFF_F000;
  localparam logic [31:0] OffsetMask   = 32'h0000_0FFF;

  typedef struct packed {
    logic [31:0] addr;
    status_e     status;
  } walk_result_t;

  logic         dir_present [DirEntries];
  int unsigned  dir_slot    [DirEntries];
  logic [31:0]  pte_store   [StoreEntries];
  int unsigned  tables_used;
  int unsigned  mismatches;
  walk_result_t walk_results_q [$];

  // Applies one word to the shadow tables and returns the result it must give.
  function automatic walk_result_t apply_page_op(logic [1:0] op, logic [31:0] va,
                                                 logic [31:0] pa, logic [11:0] fl);
    int unsigned  dix;
    int unsigned  tix;
    logic [31:0]  pte;
    walk_result_t res;
    dix = (va >> DirLsb) & (DirEntries - 1);
    tix = (va >> TableLsb) & (TableEntries - 1);
    res = '{addr: '0, status: ST_OK};
    case (op)
      OP_MAP: begin
        if (!dir_present[dix] && tables_used >= PoolTablesDef) begin
          res.status = ST_POOL_FULL;
        end else begin
          // A fresh table is swept to zero before the entry is written.
          if (!dir_present[dix]) begin
            for (int i = 0; i < TableEntries; i++) begin
              pte_store[tables_used * TableEntries + i] = '0;
            end
            dir_slot[dix]    = tables_used;
            dir_present[dix] = 1'b1;
            tables_used++;
          end
          pte_store[dir_slot[dix] * TableEntries + tix] = (pa & FrameMask) | 32'(fl);
        end
      end
      OP_UNMAP: begin
        if (dir_present[dix]) begin
          pte_store[dir_slot[dix] * TableEntries + tix] = '0;
        end
      end
      OP_TRANSLATE: begin
        pte = dir_present[dix] ? pte_store[dir_slot[dix] * TableEntries + tix] : '0;
        if (pte[0]) begin
          res.addr = (pte & FrameMask) | (va & OffsetMask);
        end else begin
          res.status = ST_MISS;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    walk_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < DirEntries; i++) begin
        dir_present[i] = 1'b0;
      end
      tables_used = 0;
      mismatches  = 0;
      walk_results_q.delete();
    end else begin
      // The result side is looked at first, so that a word appearing with
      // nothing outstanding is caught even when a new word enters alongside.
      if (out_valid_i && out_ready_i) begin
        if (walk_results_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual addr %h status %0d",
                   $time, translated_addr_i, status_i);
          mismatches++;
        end else begin
          want = walk_results_q.pop_front();
          if (translated_addr_i !== want.addr) begin
            $display("%0t: translated_addr mismatch: expected %h, actual %h",
                     $time, want.addr, translated_addr_i);
            mismatches++;
          end
          if (status_i !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        walk_results_q.push_back(apply_page_op(operation_i, virt_addr_i, phys_addr_i,
                                               entry_flags_i));
      end
    end
    error_count_o   <= mismatches;
    pending_count_o <= walk_results_q.size();
  end

endmodule

[tb/sv/two_level_page_table_manager_tb.sv]
// Top of the page table manager testbench: clock, reset, directed and random
// words with varying idle and stall rates, watchdog and verdict.
// Depends on tlpt_pkg, the block itself and tlpt_walk_checker.
module two_level_page_table_manager_tb;
  import tlpt_pkg::*;

  localparam logic [1:0]  OpUnused    = 2'd3;
  localparam int unsigned RandomWords = 600;
  localparam int unsigned FocusDirs   = 24;
  localparam int unsigned IdleLimit   = 8000;
  localparam int unsigned DrainCycles = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [31:0] virt_addr_i;
  logic [31:0] phys_addr_i;
  logic [11:0] entry_flags_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] translated_addr_o;
  logic [1:0]  status_o;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles = 0;
  logic [9:0]  focus_dir [FocusDirs];

  two_level_page_table_manager dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .virt_addr_i       (virt_addr_i),
    .phys_addr_i       (phys_addr_i),
    .entry_flags_i     (entry_flags_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .translated_addr_o (translated_addr_o),
    .status_o          (status_o)
  );

  tlpt_walk_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .operation_i       (operation_i),
    .virt_addr_i       (virt_addr_i),
    .phys_addr_i       (phys_addr_i),
    .entry_flags_i     (entry_flags_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .translated_addr_i (translated_addr_o),
    .status_i          (status_o),
    .error_count_o     (error_count),
    .pending_count_o   (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // A table allocation holds both channels quiet while the new table is swept,
  // so the limit sits well above that sweep.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("two_level_page_table_manager_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(logic [1:0] op, logic [31:0] va, logic [31:0] pa,
                           logic [11:0] fl);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    virt_addr_i   <= va;
    phys_addr_i   <= pa;
    entry_flags_i <= fl;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Most words land on a few directory slots and low table indexes, so that
  // maps, unmaps and translates meet the same entries and the pool runs dry.
  task automatic send_random_word();
    logic [1:0]  op;
    logic [31:0] va;
    logic [11:0] fl;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      op = OP_MAP;
    end else if (pick < 50) begin
      op = OP_UNMAP;
    end else if (pick < 95) begin
      op = OP_TRANSLATE;
    end else begin
      op = OpUnused;
    end
    va = $urandom();
    if ($urandom_range(0, 99) < 85) begin
      va[31:22] = focus_dir[$urandom_range(0, FocusDirs - 1)];
      if ($urandom_range(0, 9) == 0) begin
        va[21:12] = 10'h3FF - 10'($urandom_range(0, 3));
      end else begin
        va[21:12] = 10'($urandom_range(0, 7));
      end
    end
    fl = 12'($urandom());
    if ($urandom_range(0, 3) != 0) begin
      fl[0] = 1'b1;
    end
    send_word(op, va, $urandom(), fl);
  endtask

  initial begin
    in_valid_i     = 1'b0;
    operation_i    = OP_MAP;
    virt_addr_i    = '0;
    phys_addr_i    = '0;
    entry_flags_i  = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    focus_dir[0] = 10'h000;
    focus_dir[1] = 10'h3FF;
    for (int i = 2; i < FocusDirs; i++) begin
      focus_dir[i] = 10'($urandom_range(0, 1023));
    end
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words: empty tables, extremes of the index fields and flags,
    // entries without the present bit, both kinds of unmap and the unused code.
    send_word(OP_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 12'h000);
    send_word(OP_UNMAP,     32'h0000_0000, 32'h0000_0000, 12'h000);
    send_word(OP_MAP,       32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    send_word(OP_TRANSLATE, 32'h0000_0FFF, 32'h0000_0000, 12'h000);
    send_word(OP_MAP,       32'hFFFF_FFFF, 32'h1234_5ABC, 12'h001);
    send_word(OP_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    send_word(OP_MAP,       32'h0000_1000, 32'h0000_0000, 12'h000);
    send_word(OP_TRANSLATE, 32'h0000_1234, 32'h0000_0000, 12'h000);
    send_word(OP_MAP,       32'h003F_F000, 32'hABCD_E000, 12'hFFE);
    send_word(OP_TRANSLATE, 32'h003F_F800, 32'h0000_0000, 12'h000);
    send_word(OP_TRANSLATE, 32'h0000_2000, 32'h0000_0000, 12'h000);
    send_word(OP_UNMAP,     32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    send_word(OP_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 12'h000);
    send_word(OpUnused,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    send_word(OP_TRANSLATE, 32'hFFFF_F000, 32'h0000_0000, 12'h000);
    send_word(OP_MAP,       32'hFFC0_0000, 32'h8000_0000, 12'h801);
    send_word(OP_TRANSLATE, 32'hFFC0_0ABC, 32'h0000_0000, 12'h000);
    send_word(OP_TRANSLATE, 32'h0040_0000, 32'h0000_0000, 12'h000);

    for (int n = 0; n < RandomWords; n++) begin
      case (n / (RandomWords / 4))
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      send_random_word();
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("two_level_page_table_manager_tb: PASS");
    end else begin
      $display("two_level_page_table_manager_tb: FAIL");
    end
    $finish;
  end

endmodule
